// ===== design/chbd_pkg.sv =====
// shared types and constants for the canonical huffman bit decoder
// no dependencies; used by canonical_huffman_bit_decoder
`timescale 1ns / 1ps

package chbd_pkg;

  // fixed field widths
  localparam int LEN_W = 6;   // code length fields
  localparam int VAL_W = 32;  // partial code value and first codes
  localparam int SYM_W = 16;  // symbol index

  // default sizes
  localparam int MAX_CODE_LEN_DEF = 32;
  localparam int MAX_SYMBOLS_DEF  = 65536;

  // input word kinds, carried on tuser
  typedef enum logic [1:0] {
    ACT_LOAD  = 2'd0,
    ACT_BUILD = 2'd1,
    ACT_BIT   = 2'd2,
    ACT_END   = 2'd3
  } action_t;

  // output status, carried on tuser
  localparam logic STAT_SYMBOL = 1'b0;
  localparam logic STAT_ENDED  = 1'b1;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_BSUM,
    ST_BFIRST,
    ST_CMP,
    ST_INDEX,
    ST_EMIT
  } state_t;

endpackage

// ===== design/canonical_huffman_bit_decoder.sv =====
// canonical huffman decoder, bit-serial, longest codes take the smallest values
// depends on chbd_pkg
`timescale 1ns / 1ps

// Usage:
//   in channel (in_tvalid/in_tready/in_tdata/in_tuser) carries one word per
//   command; in_tuser selects load length, build tables, one coded bit or end.
//   Load words, longest code first, count symbols per length; a build word
//   walks the lengths and forms the first-code and longer-symbol tables.
//   Bit words extend the partial code; a completed code gives one out word
//   with the symbol index and code length, status 0. An end word drops any
//   partial code and gives one out word with status 1.
// Steps from acceptance until in_tready is high again: load the load state
//   (none when the length is dropped); build none when the greatest length
//   is below 2, else a sum and a first-code state for each shorter length;
//   bit the compare state, then index and emit when a symbol completes;
//   end the emit state. All arithmetic goes through one 33-bit add/subtract
//   unit under the sequencer, one operation a cycle.
// Results sit in an output register; when it is full and out_tready is low
//   the sequencer waits in its emit state until the register is free, then
//   takes input again. out_tvalid rises from the emit state, reached through
//   the compare and index states for a completing bit and directly for an end word.
// Reset clears all counts, the greatest length and the partial code; tables
//   read as zero until the first build.
module canonical_huffman_bit_decoder #(
  parameter int MAX_CODE_LEN = chbd_pkg::MAX_CODE_LEN_DEF,
  parameter int MAX_SYMBOLS  = chbd_pkg::MAX_SYMBOLS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [5:0] code_length, [6] coded_bit, [7] zero
  input  logic [1:0]  in_tuser,   // [1:0] action
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [15:0] symbol_index, [21:16] decoded_length
  output logic [0:0]  out_tuser   // [0] status
);

  localparam int IDX_W = (MAX_CODE_LEN > 1) ? $clog2(MAX_CODE_LEN) : 1;
  localparam int CNT_W = $clog2(MAX_SYMBOLS + 1);
  localparam int LEN_W = chbd_pkg::LEN_W;
  localparam int VAL_W = chbd_pkg::VAL_W;
  localparam int SYM_W = chbd_pkg::SYM_W;

  chbd_pkg::state_t state_r, state_nxt;

  // per-length tables, entry i belongs to code length i+1
  logic [CNT_W-1:0] count_r  [MAX_CODE_LEN];
  logic [VAL_W-1:0] first_r  [MAX_CODE_LEN];
  logic [CNT_W-1:0] longer_r [MAX_CODE_LEN];

  logic [LEN_W-1:0] greatest_r;
  logic [LEN_W-1:0] built_g_r;   // greatest length at last build, masks stale entries
  logic [CNT_W-1:0] total_r;
  logic [CNT_W-1:0] sum_r;
  logic [VAL_W-1:0] fprev_r;     // first code of the length being walked
  logic [VAL_W-1:0] diff_r;
  logic [IDX_W-1:0] idx_r;
  logic [VAL_W-1:0] pv_r;
  logic [LEN_W-1:0] plen_r;

  logic [SYM_W-1:0] res_idx_r;
  logic [LEN_W-1:0] res_len_r;
  logic             res_stat_r;

  logic             out_valid_r;
  logic [23:0]      out_data_r;
  logic             out_user_r;

  // input word decode
  chbd_pkg::action_t in_act;
  logic [LEN_W-1:0]  in_len;
  logic              in_bit;
  logic              in_fire;
  logic              load_ok;

  assign in_act  = chbd_pkg::action_t'(in_tuser);
  assign in_len  = in_tdata[LEN_W-1:0];
  assign in_bit  = in_tdata[LEN_W];
  assign in_fire = in_tvalid && in_tready;
  assign load_ok = (in_len != '0) && (in_len <= LEN_W'(MAX_CODE_LEN)) &&
                   (total_r < CNT_W'(MAX_SYMBOLS));

  // table reads
  logic [IDX_W-1:0] tidx;
  logic             tbl_zero;
  logic [VAL_W-1:0] first_rd;
  logic [CNT_W-1:0] longer_rd;
  logic [CNT_W-1:0] count_rd;
  logic             plen_full;

  assign tidx      = IDX_W'(plen_r - LEN_W'(1));
  assign tbl_zero  = (plen_r >= built_g_r);
  assign first_rd  = tbl_zero ? '0 : first_r[tidx];
  assign longer_rd = tbl_zero ? '0 : longer_r[tidx];
  assign count_rd  = count_r[idx_r];
  assign plen_full = (plen_r == LEN_W'(MAX_CODE_LEN));

  // shared add/subtract unit
  logic [VAL_W-1:0] alu_a, alu_b;
  logic             alu_sub;
  logic [VAL_W:0]   alu_y;

  assign alu_y = alu_sub ? ({1'b0, alu_a} - {1'b0, alu_b})
                         : ({1'b0, alu_a} + {1'b0, alu_b});

  logic out_free;
  assign out_free = !out_valid_r || out_tready;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      chbd_pkg::ST_IDLE: begin
        if (in_fire) begin
          case (in_act)
            chbd_pkg::ACT_LOAD:  state_nxt = load_ok ? chbd_pkg::ST_LOAD : chbd_pkg::ST_IDLE;
            chbd_pkg::ACT_BUILD: state_nxt = (greatest_r > LEN_W'(1)) ? chbd_pkg::ST_BSUM
                                                                       : chbd_pkg::ST_IDLE;
            chbd_pkg::ACT_BIT:   state_nxt = chbd_pkg::ST_CMP;
            chbd_pkg::ACT_END:   state_nxt = chbd_pkg::ST_EMIT;
            default:             state_nxt = chbd_pkg::ST_IDLE;
          endcase
        end
      end
      chbd_pkg::ST_LOAD:   state_nxt = chbd_pkg::ST_IDLE;
      chbd_pkg::ST_BSUM:   state_nxt = chbd_pkg::ST_BFIRST;
      chbd_pkg::ST_BFIRST: state_nxt = (idx_r == IDX_W'(1)) ? chbd_pkg::ST_IDLE
                                                            : chbd_pkg::ST_BSUM;
      chbd_pkg::ST_CMP:    state_nxt = (!alu_y[VAL_W] || plen_full) ? chbd_pkg::ST_INDEX
                                                                    : chbd_pkg::ST_IDLE;
      chbd_pkg::ST_INDEX:  state_nxt = chbd_pkg::ST_EMIT;
      chbd_pkg::ST_EMIT:   state_nxt = out_free ? chbd_pkg::ST_IDLE : chbd_pkg::ST_EMIT;
      default:             state_nxt = chbd_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer: ready and operand selection
  always_comb begin
    in_tready = 1'b0;
    alu_a     = '0;
    alu_b     = '0;
    alu_sub   = 1'b0;
    case (state_r)
      chbd_pkg::ST_IDLE:   in_tready = 1'b1;
      chbd_pkg::ST_LOAD: begin
        alu_a = VAL_W'(count_rd);
        alu_b = VAL_W'(1);
      end
      chbd_pkg::ST_BSUM: begin
        alu_a = VAL_W'(sum_r);
        alu_b = VAL_W'(count_rd);
      end
      chbd_pkg::ST_BFIRST: begin
        alu_a = fprev_r;
        alu_b = VAL_W'(count_rd);
      end
      chbd_pkg::ST_CMP: begin
        // borrow out means the value is below the first code
        alu_a   = pv_r;
        alu_b   = first_rd;
        alu_sub = 1'b1;
      end
      chbd_pkg::ST_INDEX: begin
        alu_a = VAL_W'(longer_rd);
        alu_b = diff_r;
      end
      default: ;
    endcase
  end

  // control and counts
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= chbd_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      greatest_r  <= '0;
      built_g_r   <= '0;
      total_r     <= '0;
      pv_r        <= '0;
      plen_r      <= '0;
      for (int i = 0; i < MAX_CODE_LEN; i++) begin
        count_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;

      if (state_r == chbd_pkg::ST_EMIT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        chbd_pkg::ST_IDLE: begin
          if (in_fire) begin
            case (in_act)
              chbd_pkg::ACT_LOAD: begin
                if (load_ok) begin
                  total_r <= total_r + CNT_W'(1);
                  if (in_len > greatest_r) begin
                    greatest_r <= in_len;
                  end
                end
              end
              chbd_pkg::ACT_BUILD: begin
                pv_r      <= '0;
                plen_r    <= '0;
                built_g_r <= greatest_r;
              end
              chbd_pkg::ACT_BIT: begin
                pv_r <= {pv_r[VAL_W-2:0], in_bit};
                if (!plen_full) begin
                  plen_r <= plen_r + LEN_W'(1);
                end
              end
              chbd_pkg::ACT_END: begin
                pv_r   <= '0;
                plen_r <= '0;
              end
              default: ;
            endcase
          end
        end
        chbd_pkg::ST_LOAD:  count_r[idx_r] <= alu_y[CNT_W-1:0];
        chbd_pkg::ST_INDEX: begin
          pv_r   <= '0;
          plen_r <= '0;
        end
        default: ;
      endcase
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk) begin
    case (state_r)
      chbd_pkg::ST_IDLE: begin
        if (in_fire) begin
          case (in_act)
            chbd_pkg::ACT_LOAD:  idx_r <= IDX_W'(in_len - LEN_W'(1));
            chbd_pkg::ACT_BUILD: begin
              // walk starts at the greatest length, its first code is zero
              idx_r   <= IDX_W'(greatest_r - LEN_W'(1));
              sum_r   <= '0;
              fprev_r <= '0;
            end
            chbd_pkg::ACT_END: begin
              res_idx_r  <= '0;
              res_len_r  <= '0;
              res_stat_r <= chbd_pkg::STAT_ENDED;
            end
            default: ;
          endcase
        end
      end
      chbd_pkg::ST_BSUM: begin
        sum_r                         <= alu_y[CNT_W-1:0];
        longer_r[IDX_W'(idx_r - 1'b1)] <= alu_y[CNT_W-1:0];
      end
      chbd_pkg::ST_BFIRST: begin
        // halve the sum to step one length shorter
        first_r[IDX_W'(idx_r - 1'b1)] <= alu_y[VAL_W:1];
        fprev_r                       <= alu_y[VAL_W:1];
        idx_r                         <= IDX_W'(idx_r - 1'b1);
      end
      chbd_pkg::ST_CMP:   diff_r <= alu_y[VAL_W-1:0];
      chbd_pkg::ST_INDEX: begin
        res_idx_r  <= alu_y[SYM_W-1:0];
        res_len_r  <= plen_r;
        res_stat_r <= chbd_pkg::STAT_SYMBOL;
      end
      chbd_pkg::ST_EMIT: begin
        if (out_free) begin
          out_data_r <= {2'b00, res_len_r, res_idx_r};
          out_user_r <= res_stat_r;
        end
      end
      default: ;
    endcase
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;
  assign out_tuser[0] = out_user_r;

endmodule

// ===== tb/tb_canonical_huffman_bit_decoder.sv =====
// self-checking testbench for the canonical huffman bit decoder: directed words,
// then random code sets, coded symbols and noise, all checked against a predictor
// depends on chbd_pkg and canonical_huffman_bit_decoder
`timescale 1ns / 1ps

// one out word as the predictor expects it
typedef struct packed {
  logic [15:0] symbol_index;
  logic [5:0]  decoded_length;
  logic        status;
} decode_result_t;

// predictor of the decoder plus the queue of words still owed by it
class huffman_scoreboard;
  logic [16:0]    len_count [chbd_pkg::MAX_CODE_LEN_DEF];
  logic [31:0]    first_code [chbd_pkg::MAX_CODE_LEN_DEF];
  logic [16:0]    longer_count [chbd_pkg::MAX_CODE_LEN_DEF];
  logic [5:0]     max_len;
  logic [31:0]    code_value;
  logic [5:0]     code_bits;
  logic [16:0]    lengths_loaded;
  decode_result_t owed_q[$];
  int unsigned    mismatches;
  int unsigned    symbols_matched;
  int unsigned    ends_matched;

  function new();
    foreach (len_count[k]) begin
      len_count[k]    = '0;
      first_code[k]   = '0;
      longer_count[k] = '0;
    end
    max_len        = '0;
    code_value     = '0;
    code_bits      = '0;
    lengths_loaded = '0;
    mismatches     = 0;
    symbols_matched = 0;
    ends_matched   = 0;
  endfunction

  function int pending();
    return owed_q.size();
  endfunction

  // update the predicted state for one accepted in word
  function void note_input(chbd_pkg::action_t act, logic [5:0] len, logic b);
    decode_result_t res;
    logic [31:0]    run_sum;
    logic [31:0]    idx;
    int             k;
    case (act)
      chbd_pkg::ACT_LOAD: begin
        if (len >= 1 && len <= chbd_pkg::MAX_CODE_LEN_DEF &&
            lengths_loaded < 17'(chbd_pkg::MAX_SYMBOLS_DEF)) begin
          len_count[len - 1] = len_count[len - 1] + 1'b1;
          lengths_loaded     = lengths_loaded + 1'b1;
          if (len > max_len) max_len = len;
        end
      end
      chbd_pkg::ACT_BUILD: begin
        foreach (first_code[j]) begin
          first_code[j]   = '0;
          longer_count[j] = '0;
        end
        run_sum = '0;
        // greatest length keeps first code zero, shorter ones halve upward
        for (k = int'(max_len) - 1; k > 0; k--) begin
          run_sum           = run_sum + 32'(len_count[k]);
          longer_count[k-1] = run_sum[16:0];
          first_code[k-1]   = (first_code[k] + 32'(len_count[k])) >> 1;
        end
        code_value = '0;
        code_bits  = '0;
      end
      chbd_pkg::ACT_BIT: begin
        code_value = {code_value[30:0], b};
        if (code_bits < chbd_pkg::MAX_CODE_LEN_DEF) code_bits = code_bits + 1'b1;
        if (code_value >= first_code[code_bits - 1] ||
            code_bits == chbd_pkg::MAX_CODE_LEN_DEF) begin
          idx = 32'(longer_count[code_bits - 1]) + code_value - first_code[code_bits - 1];
          res.symbol_index   = idx[15:0];
          res.decoded_length = code_bits;
          res.status         = chbd_pkg::STAT_SYMBOL;
          owed_q = {owed_q, res};
          code_value = '0;
          code_bits  = '0;
        end
      end
      default: begin
        code_value = '0;
        code_bits  = '0;
        res.symbol_index   = '0;
        res.decoded_length = '0;
        res.status         = chbd_pkg::STAT_ENDED;
        owed_q = {owed_q, res};
      end
    endcase
  endfunction

  task report(string msg);
    $display("mismatch: %s", msg);
    mismatches++;
  endtask

  // compare one accepted out word with the oldest owed word
  task check_result(logic [15:0] sym, logic [5:0] len, logic st);
    decode_result_t want;
    if (owed_q.size() == 0) begin
      report($sformatf("unexpected word index %0d length %0d status %0d", sym, len, st));
      return;
    end
    want = owed_q.pop_front();
    if (sym !== want.symbol_index)
      report($sformatf("symbol index %0d, predicted %0d", sym, want.symbol_index));
    if (len !== want.decoded_length)
      report($sformatf("decoded length %0d, predicted %0d", len, want.decoded_length));
    if (st !== want.status)
      report($sformatf("status %0d, predicted %0d", st, want.status));
    if (want.status == chbd_pkg::STAT_ENDED) ends_matched++;
    else symbols_matched++;
  endtask
endclass

module tb_canonical_huffman_bit_decoder;

  localparam int MAX_LEN     = chbd_pkg::MAX_CODE_LEN_DEF;
  localparam int PHASE_WORDS = 430;        // random words per idling phase
  localparam int DRAIN       = 80;         // covers the longest build walk
  localparam int LIMIT       = 200_000;    // watchdog limit for the whole run

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;   // [5:0] code_length, [6] coded_bit, [7] zero
  logic [1:0]  in_tuser = chbd_pkg::ACT_LOAD;  // [1:0] action
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;       // [15:0] symbol_index, [21:16] decoded_length
  logic [0:0]  out_tuser;       // [0] status

  huffman_scoreboard sb = new();

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned words_sent = 0;
  int unsigned cycle_count = 0;

  canonical_huffman_bit_decoder u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #5 clk = ~clk;

  // watchdog: a hang anywhere ends the run as a failure
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT) begin
      $display("timeout after %0d cycles, %0d words still owed", cycle_count, sb.pending());
      $display("simulation failed");
      $finish;
    end
  end

  // receiver: check every accepted out word, then pick next cycle's ready
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_result(out_tdata[15:0], out_tdata[21:16], out_tuser[0]);
    out_tready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
  end

  // present one word, hold it until the handshake, then tell the predictor;
  // valid stays high on return so back-to-back words need no second assignment
  task automatic send_word(input chbd_pkg::action_t act, input logic [5:0] len,
                           input logic b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= {1'b0, b, len};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_input(act, len, b);
    words_sent++;
  endtask

  // lower valid and wait until the block has returned every owed word
  task automatic settle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // a complete prefix code built by splitting leaves, loaded longest first;
  // a chain always splits the deepest leaf and can reach 32-bit codes
  task automatic load_code_set(input int splits, input bit chain);
    int lens[$];
    int pick;
    lens = '{1, 1};
    repeat (splits) begin
      lens.rsort();
      pick = chain ? 0 : $urandom_range(lens.size() - 1);
      if (lens[pick] < MAX_LEN) begin
        lens = {lens, lens[pick] + 1};
        lens[pick] = lens[pick] + 1;
      end
    end
    lens.rsort();
    foreach (lens[i]) send_word(chbd_pkg::ACT_LOAD, 6'(lens[i]), 1'($urandom));
  endtask

  // send the bits of a code valid for the current tables, msb first;
  // cut_short stops inside the code and ends the stream
  task automatic send_symbol(input bit cut_short);
    int          l;
    int          n;
    logic [31:0] code;
    l = 1;
    if (sb.max_len != 0) begin
      repeat (8) begin
        l = $urandom_range(1, sb.max_len);
        if (sb.len_count[l-1] != 0) break;
      end
    end
    code = sb.first_code[l-1];
    if (sb.len_count[l-1] != 0) code = code + $urandom_range(0, sb.len_count[l-1] - 1);
    n = cut_short ? $urandom_range(0, l - 1) : l;
    for (int i = 0; i < n; i++) send_word(chbd_pkg::ACT_BIT, 6'($urandom), code[l-1-i]);
    if (cut_short) send_word(chbd_pkg::ACT_END, 6'($urandom), 1'($urandom));
  endtask

  // one session: maybe a new code set, a build, then mostly clean symbols
  // with stray ends, loose bits, dropped lengths and mid-code rebuilds
  task automatic run_session();
    int  splits;
    bit  chain;
    splits = ($urandom_range(9) == 0) ? MAX_LEN - 1 : $urandom_range(1, 10);
    chain  = (splits == MAX_LEN - 1) || ($urandom_range(3) == 0);
    if ($urandom_range(3) != 0) load_code_set(splits, chain);
    send_word(chbd_pkg::ACT_BUILD, 6'($urandom), 1'($urandom));
    repeat ($urandom_range(4, 16)) begin
      case ($urandom_range(19))
        0: send_word(chbd_pkg::ACT_END, 6'($urandom), 1'($urandom));
        1: send_symbol(1'b1);
        2: send_word(chbd_pkg::ACT_BIT, 6'($urandom), 1'($urandom));
        3: send_word(chbd_pkg::ACT_LOAD,
                     $urandom_range(1) ? 6'd0 : 6'($urandom_range(33, 63)),
                     1'($urandom));
        4: send_word(chbd_pkg::ACT_BUILD, 6'($urandom), 1'($urandom));
        default: send_symbol(1'b0);
      endcase
    end
    send_word(chbd_pkg::ACT_END, 6'($urandom), 1'($urandom));
  endtask

  initial begin
    int unsigned target;
    send_idle_pct = 37;
    recv_idle_pct = 62;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: bits before any build complete at length 1
    send_word(chbd_pkg::ACT_BIT, 6'd0, 1'b1);
    send_word(chbd_pkg::ACT_BIT, 6'd0, 1'b0);
    send_word(chbd_pkg::ACT_END, 6'd0, 1'b0);
    // build with nothing loaded, then a bit with all unused bits high
    send_word(chbd_pkg::ACT_BUILD, 6'd0, 1'b0);
    send_word(chbd_pkg::ACT_BIT, 6'h3f, 1'b1);
    // lengths zero and above the maximum are dropped
    send_word(chbd_pkg::ACT_LOAD, 6'd0, 1'b0);
    send_word(chbd_pkg::ACT_LOAD, 6'd33, 1'b1);
    send_word(chbd_pkg::ACT_LOAD, 6'd63, 1'b0);
    // complete code 3,3,2,1
    send_word(chbd_pkg::ACT_LOAD, 6'd3, 1'b0);
    send_word(chbd_pkg::ACT_LOAD, 6'd3, 1'b0);
    send_word(chbd_pkg::ACT_LOAD, 6'd2, 1'b0);
    send_word(chbd_pkg::ACT_LOAD, 6'd1, 1'b0);
    send_word(chbd_pkg::ACT_BUILD, 6'd0, 1'b0);
    // end while a code is partial drops it
    send_word(chbd_pkg::ACT_BIT, 6'd0, 1'b0);
    send_word(chbd_pkg::ACT_END, 6'd0, 1'b0);
    // one code of each length
    send_word(chbd_pkg::ACT_BIT, 6'd0, 1'b1);
    send_word(chbd_pkg::ACT_BIT, 6'd0, 1'b0);
    send_word(chbd_pkg::ACT_BIT, 6'd0, 1'b1);
    send_word(chbd_pkg::ACT_BIT, 6'd0, 1'b0);
    send_word(chbd_pkg::ACT_BIT, 6'd0, 1'b0);
    send_word(chbd_pkg::ACT_BIT, 6'd0, 1'b0);
    // longest length accumulates onto the old counts; rebuild mid-code
    send_word(chbd_pkg::ACT_LOAD, 6'd32, 1'b1);
    send_word(chbd_pkg::ACT_BUILD, 6'd0, 1'b0);
    send_word(chbd_pkg::ACT_BIT, 6'd0, 1'b0);
    send_word(chbd_pkg::ACT_BUILD, 6'd0, 1'b0);
    send_word(chbd_pkg::ACT_BIT, 6'd0, 1'b1);
    settle();

    // random phases: slow sender/slow receiver, then swapped, then full rate
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 37 : (phase == 1) ? 62 : 0;
      recv_idle_pct = (phase == 0) ? 62 : (phase == 1) ? 37 : 0;
      target = words_sent + PHASE_WORDS;
      while (words_sent < target) run_session();
      settle();
    end

    repeat (DRAIN) @(posedge clk);

    $display("checked %0d decoded symbols and %0d stream ends from %0d words",
             sb.symbols_matched, sb.ends_matched, words_sent);
    $display("code lengths held at the end: %0d, greatest length %0d",
             sb.lengths_loaded, sb.max_len);
    if (sb.mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("simulation failed");
    end
    $finish;
  end

endmodule
